// ===== hw/rtl/polyphonic_waveform_oscillator_defines.svh =====
// Assertion helpers shared by the oscillator RTL.
`ifndef POLYPHONIC_WAVEFORM_OSCILLATOR_DEFINES_SVH
`define POLYPHONIC_WAVEFORM_OSCILLATOR_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define PWO_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PWO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/pwo_pkg.sv =====
package pwo_pkg;

    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [31:0] PHASE_SCALE_RESET = 32'd22906492;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WAVEFORM       = 3'd0,
        REG_OCTAVE_SHIFT   = 3'd1,
        REG_SEMITONE_SHIFT = 3'd2,
        REG_CENTS_SHIFT    = 3'd3,
        REG_PHASE_SCALE    = 3'd4
    } t_reg_idx;

    typedef enum logic [1:0] {
        WAVE_SINE     = 2'd0,
        WAVE_TRIANGLE = 2'd1,
        WAVE_SQUARE   = 2'd2,
        WAVE_SAW      = 2'd3
    } t_wave;

    typedef struct packed {
        logic [3:0]  voice_index;
        logic        sounding;
        logic        note_end;
        logic [31:0] base_frequency;
    } t_item;

    typedef struct packed {
        logic [3:0]         voice_out;
        logic signed [15:0] sample_value;
    } t_result;

    typedef struct packed {
        t_wave              waveform;
        logic signed [4:0]  octave_shift;
        logic signed [4:0]  semitone_shift;
        logic signed [7:0]  cents_shift;
        logic [31:0]        phase_scale;
    } t_cfg;

    // one strobe per sequencer step
    typedef struct packed {
        logic capture;
        logic mem_rd;
        logic quot_fix;
        logic digit_hi;
        logic digit_lo;
        logic factor_a;
        logic factor_b;
        logic mul_base;
        logic mul_lo;
        logic mul_hi;
        logic write_back;
    } t_dp_cmd;

    // odd Taylor terms of sin(pi*x/2), Q30
    localparam logic [63:0] C1 = 64'd1686629713;
    localparam logic [63:0] C3 = 64'd693598669;
    localparam logic [63:0] C5 = 64'd85569306;
    localparam logic [63:0] C7 = 64'd5026996;
    localparam logic [63:0] C9 = 64'd172272;
    localparam logic [63:0] Q30_ONE = 64'h4000_0000;

    // 2^(s/12) in Q16
    function automatic logic [16:0] semi_q16(input logic [3:0] idx);
        logic [16:0] v;
        case (idx)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd69433;
            4'd2:    v = 17'd73562;
            4'd3:    v = 17'd77936;
            4'd4:    v = 17'd82570;
            4'd5:    v = 17'd87480;
            4'd6:    v = 17'd92682;
            4'd7:    v = 17'd98193;
            4'd8:    v = 17'd104032;
            4'd9:    v = 17'd110218;
            4'd10:   v = 17'd116772;
            4'd11:   v = 17'd123715;
            default: v = 17'd65536;
        endcase
        return v;
    endfunction

    // 2^(10t/1200) in Q16
    function automatic logic [16:0] tens_q16(input logic [3:0] idx);
        logic [16:0] v;
        case (idx)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd65916;
            4'd2:    v = 17'd66297;
            4'd3:    v = 17'd66682;
            4'd4:    v = 17'd67068;
            4'd5:    v = 17'd67456;
            4'd6:    v = 17'd67847;
            4'd7:    v = 17'd68240;
            4'd8:    v = 17'd68635;
            4'd9:    v = 17'd69033;
            default: v = 17'd65536;
        endcase
        return v;
    endfunction

    // 2^(u/1200) in Q16
    function automatic logic [16:0] units_q16(input logic [3:0] idx);
        logic [16:0] v;
        case (idx)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd65574;
            4'd2:    v = 17'd65612;
            4'd3:    v = 17'd65650;
            4'd4:    v = 17'd65688;
            4'd5:    v = 17'd65726;
            4'd6:    v = 17'd65764;
            4'd7:    v = 17'd65802;
            4'd8:    v = 17'd65840;
            4'd9:    v = 17'd65878;
            default: v = 17'd65536;
        endcase
        return v;
    endfunction

    // sin(pi*x/2), x in Q30 on [0,1], result Q15 saturated
    function automatic logic [15:0] quarter_sine(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] y;
        logic [63:0] s;
        x2 = (x * x) >> 30;
        y  = C9;
        y  = C7 - ((x2 * y) >> 30);
        y  = C5 - ((x2 * y) >> 30);
        y  = C3 - ((x2 * y) >> 30);
        y  = C1 - ((x2 * y) >> 30);
        s  = ((x * y) >> 30) + 64'd16384;
        s  = s >> 15;
        return (s > 64'd32767) ? 16'd32767 : s[15:0];
    endfunction

    // one sine table entry, evaluated at elaboration
    function automatic logic signed [15:0] sine_entry(input logic [31:0] k,
                                                      input int unsigned bits);
        logic [31:0] u;
        logic [63:0] x;
        logic [15:0] s;
        u = k << (32 - bits);
        x = u[30] ? (Q30_ONE - 64'(u[29:0])) : 64'(u[29:0]);
        s = quarter_sine(x);
        return u[31] ? -signed'(s) : signed'(s);
    endfunction

endpackage

// ===== hw/rtl/pwo_ctrl.sv =====
`include "polyphonic_waveform_oscillator_defines.svh"

module pwo_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    output pwo_pkg::t_dp_cmd o_cmd
);
    import pwo_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_RD   = 11'b000_0000_0010,
        S_QFIX = 11'b000_0000_0100,
        S_DHI  = 11'b000_0000_1000,
        S_DLO  = 11'b000_0001_0000,
        S_FA   = 11'b000_0010_0000,
        S_FB   = 11'b000_0100_0000,
        S_MB   = 11'b000_1000_0000,
        S_ML   = 11'b001_0000_0000,
        S_MH   = 11'b010_0000_0000,
        S_WB   = 11'b100_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (start) n_state = S_RD;
            S_RD:    n_state = S_QFIX;
            S_QFIX:  n_state = S_DHI;
            S_DHI:   n_state = S_DLO;
            S_DLO:   n_state = S_FA;
            S_FA:    n_state = S_FB;
            S_FB:    n_state = S_MB;
            S_MB:    n_state = S_ML;
            S_ML:    n_state = S_MH;
            S_MH:    n_state = S_WB;
            S_WB:    n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

    always_comb begin
        o_cmd            = '0;
        o_cmd.capture    = (r_state == S_IDLE) && start;
        o_cmd.mem_rd     = (r_state == S_RD);
        o_cmd.quot_fix   = (r_state == S_QFIX);
        o_cmd.digit_hi   = (r_state == S_DHI);
        o_cmd.digit_lo   = (r_state == S_DLO);
        o_cmd.factor_a   = (r_state == S_FA);
        o_cmd.factor_b   = (r_state == S_FB);
        o_cmd.mul_base   = (r_state == S_MB);
        o_cmd.mul_lo     = (r_state == S_ML);
        o_cmd.mul_hi     = (r_state == S_MH);
        o_cmd.write_back = (r_state == S_WB);
    end

    `PWO_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, start && !busy, r_state == S_RD, "accepted tick did not start the sequence")
    `PWO_ASSERT_NEXT(a_wb_frees, i_clk, i_rst_n, r_state == S_WB, !busy, "block still busy after write back")
    `PWO_ASSERT_SAME(a_capture_idle, i_clk, i_rst_n, o_cmd.capture, !busy && !o_cmd.write_back, "capture outside idle")

endmodule

// ===== hw/rtl/pwo_datapath.sv =====
`include "polyphonic_waveform_oscillator_defines.svh"

module pwo_datapath #(
    parameter int unsigned VOICES          = 16,
    parameter int unsigned SINE_TABLE_BITS = 10
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pwo_pkg::t_dp_cmd i_cmd,
    input  pwo_pkg::t_cfg    i_cfg,
    input  pwo_pkg::t_item   i_item,
    output logic             o_result_strobe,
    output pwo_pkg::t_result o_result
);
    import pwo_pkg::*;

    localparam int unsigned ADDR_W = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int unsigned SINE_N = 1 << SINE_TABLE_BITS;
    localparam logic [33:0] ONE34  = 34'h1_0000_0000;

    // voice state
    logic [31:0]        mem_phase  [VOICES];
    logic signed [15:0] mem_sample [VOICES];
    logic [VOICES-1:0]  r_vld;

    logic signed [15:0] w_sine_rom [SINE_N];

    t_item              r_item;
    logic               r_in_range;
    logic [15:0]        r_t;
    logic [5:0]         r_qe;
    logic [31:0]        r_ph_rd;
    logic signed [15:0] r_smp_rd;
    logic               r_vld_rd;
    logic [10:0]        r_r;
    logic [5:0]         r_s;
    logic signed [15:0] r_sine;
    logic [3:0]         r_si;
    logic [6:0]         r_r2;
    logic [3:0]         r_ti;
    logic [3:0]         r_ui;
    logic [16:0]        r_f1;
    logic [16:0]        r_f;
    logic signed [15:0] r_wave;
    logic [48:0]        r_x;
    logic [63:0]        r_p0;
    logic [49:0]        r_mid;
    logic               r_strobe;
    t_result            r_result;

    logic [8:0]         w_in_idx_ext;
    logic [8:0]         w_idx_ext;
    logic [ADDR_W-1:0]  w_addr;
    logic signed [17:0] w_total;
    logic signed [17:0] w_t;
    logic [31:0]        w_qprod;
    logic [15:0]        w_rem;
    logic               w_qfix;
    logic [6:0]         w_q;
    logic [6:0]         w_s;
    logic [23:0]        w_sip;
    logic [14:0]        w_tp;
    logic [33:0]        w_f1p;
    logic [33:0]        w_f2p;
    logic [81:0]        w_prod;
    logic [81:0]        w_shifted;
    logic [31:0]        w_inc;
    logic [31:0]        w_ph;
    logic signed [15:0] w_smp;
    logic               w_we;
    logic [31:0]        n_phase;
    logic signed [15:0] n_sample;
    logic signed [15:0] w_out_sample;

    logic               w_lower;
    logic [31:0]        w_centre;
    logic [31:0]        w_dist;
    logic [33:0]        w_d4;
    logic               w_tri_ge;
    logic [33:0]        w_tri_mag;
    logic               w_tri_neg;
    logic [33:0]        w_two_p;
    logic               w_saw_neg;
    logic [33:0]        w_saw_mag;
    logic signed [15:0] w_wave;

    function automatic logic signed [15:0] q32_to_q15(input logic [33:0] mag,
                                                      input logic neg);
        logic [33:0] v;
        logic [15:0] r;
        v = (mag + 34'h1_0000) >> 17;
        r = (v > 34'd32767) ? 16'd32767 : v[15:0];
        return neg ? -signed'(r) : signed'(r);
    endfunction

    for (genvar k = 0; k < SINE_N; k++) begin : g_rom
        assign w_sine_rom[k] = sine_entry(32'(k), SINE_TABLE_BITS);
    end

    assign w_in_idx_ext = 9'(i_item.voice_index);
    assign w_idx_ext    = 9'(r_item.voice_index);
    assign w_addr       = w_idx_ext[ADDR_W-1:0];

    // pitch offset in cents, biased so the octave split works on unsigned values
    assign w_total = 18'(i_cfg.octave_shift) * 18'sd1200
                   + 18'(i_cfg.semitone_shift) * 18'sd100
                   + 18'(i_cfg.cents_shift);
    assign w_t     = w_total + 18'sd38400;

    // floor(t/1200) estimate, low by at most one
    assign w_qprod = 32'(r_t) * 32'd55924;
    assign w_rem   = r_t - 16'(r_qe) * 16'd1200;
    assign w_qfix  = (w_rem >= 16'd1200);
    assign w_q     = 7'(r_qe) + 7'(w_qfix);
    assign w_s     = 7'd72 - w_q;

    assign w_sip = 24'(r_r) * 24'd5243;
    assign w_tp  = 15'(r_r2) * 15'd205;
    assign w_f1p = 34'(semi_q16(r_si)) * 34'(tens_q16(r_ti)) + 34'd32768;
    assign w_f2p = 34'(r_f1) * 34'(units_q16(r_ui)) + 34'd32768;

    assign w_prod    = {r_mid, r_p0[31:0]};
    assign w_shifted = w_prod >> r_s;
    assign w_inc     = w_shifted[31:0];

    assign w_ph  = r_vld_rd ? r_ph_rd : 32'd0;
    assign w_smp = r_vld_rd ? r_smp_rd : 16'sd0;

    always_comb begin
        w_lower   = ~w_ph[31];
        w_centre  = w_lower ? 32'h4000_0000 : 32'hC000_0000;
        w_dist    = (w_ph > w_centre) ? (w_ph - w_centre) : (w_centre - w_ph);
        w_d4      = {w_dist, 2'b00};
        w_tri_ge  = (w_d4 >= ONE34);
        w_tri_mag = w_tri_ge ? (w_d4 - ONE34) : (ONE34 - w_d4);
        w_tri_neg = w_lower ? (w_d4 > ONE34) : !w_tri_ge;
        w_two_p   = {1'b0, w_ph, 1'b0};
        w_saw_neg = (w_two_p > ONE34);
        w_saw_mag = w_saw_neg ? (w_two_p - ONE34) : (ONE34 - w_two_p);
        case (i_cfg.waveform)
            WAVE_SINE:     w_wave = r_sine;
            WAVE_TRIANGLE: w_wave = q32_to_q15(w_tri_mag, w_tri_neg);
            WAVE_SQUARE:   w_wave = w_ph[31] ? -16'sd32767 : 16'sd32767;
            WAVE_SAW:      w_wave = q32_to_q15(w_saw_mag, w_saw_neg);
            default:       w_wave = r_sine;
        endcase
    end

    assign w_we     = i_cmd.write_back && r_in_range && r_item.sounding;
    assign n_phase  = r_item.note_end ? 32'd0 : (w_ph + w_inc);
    assign n_sample = r_item.note_end ? 16'sd0 : r_wave;

    always_comb begin
        if (!r_in_range) begin
            w_out_sample = 16'sd0;
        end else if (r_item.sounding) begin
            w_out_sample = n_sample;
        end else begin
            w_out_sample = w_smp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.write_back;
            if (w_we) begin
                r_vld[w_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_rd) begin
            r_ph_rd  <= mem_phase[w_addr];
            r_smp_rd <= mem_sample[w_addr];
            r_vld_rd <= r_vld[w_addr];
        end
        if (w_we) begin
            mem_phase[w_addr]  <= n_phase;
            mem_sample[w_addr] <= n_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item     <= i_item;
            r_in_range <= (w_in_idx_ext < 9'(VOICES));
            r_t        <= w_t[15:0];
        end
        if (i_cmd.mem_rd) begin
            r_qe <= w_qprod[31:26];
        end
        if (i_cmd.quot_fix) begin
            r_r    <= 11'(w_qfix ? (w_rem - 16'd1200) : w_rem);
            r_s    <= w_s[5:0];
            r_sine <= w_sine_rom[w_ph[31 -: SINE_TABLE_BITS]];
        end
        if (i_cmd.digit_hi) begin
            r_si <= w_sip[22:19];
            r_r2 <= 7'(r_r - 11'(w_sip[22:19]) * 11'd100);
        end
        if (i_cmd.digit_lo) begin
            r_ti <= w_tp[14:11];
            r_ui <= 4'(r_r2 - 7'(w_tp[14:11]) * 7'd10);
        end
        if (i_cmd.factor_a) begin
            r_f1   <= w_f1p[32:16];
            r_wave <= w_wave;
        end
        if (i_cmd.factor_b) begin
            r_f <= w_f2p[32:16];
        end
        if (i_cmd.mul_base) begin
            r_x <= 49'(r_item.base_frequency) * 49'(r_f);
        end
        if (i_cmd.mul_lo) begin
            r_p0 <= 64'(r_x[31:0]) * 64'(i_cfg.phase_scale);
        end
        if (i_cmd.mul_hi) begin
            r_mid <= 50'(r_p0[63:32]) + 50'(r_x[48:32]) * 50'(i_cfg.phase_scale);
        end
        if (i_cmd.write_back) begin
            r_result.voice_out    <= r_item.voice_index;
            r_result.sample_value <= w_out_sample;
        end
    end

    assign o_result_strobe = r_strobe;
    assign o_result        = r_result;

    `PWO_ASSERT_SAME(a_strobe_after_wb, i_clk, i_rst_n, r_strobe, $past(i_cmd.write_back), "result strobe without write back")
    `PWO_ASSERT_SAME(a_rem_reduced, i_clk, i_rst_n, i_cmd.digit_hi, r_r < 11'd1200, "cent remainder not reduced below one octave")
    `PWO_ASSERT_SAME(a_shift_range, i_clk, i_rst_n, i_cmd.write_back, (r_s >= 6'd24) && (r_s <= 6'd58), "increment shift out of range")

endmodule

// ===== hw/rtl/polyphonic_waveform_oscillator.sv =====
// Polyphonic waveform oscillator: one phase accumulator and one held sample per voice.
// Tick channel: start/busy with an item struct (voice index, sounding, note end,
// base frequency UQ16.16 Hz). A tick is taken when start is high and busy low.
// Result channel: o_result carries the voice index and its stored Q1.15 sample,
// valid for exactly one cycle while o_result_strobe is high. The receiver must
// take it; there is no backpressure.
// Config channel: i_cfg_valid/o_cfg_ready with a register index and 32-bit data;
// ready is always high. Write only while busy is low and no result is pending.
// Sequencing: the strobe rises and busy drops in the same cycle, once the write
// back is done, so a new tick is not taken before the last one is through. The
// sequencer walks the tuning math through one multiply per step (cent split,
// two table products, then base * factor * phase scale in three partial products)
// followed by a single voice-memory write back.
// Reset (synchronous, active low) restores the register defaults, clears all voice
// phases and samples through per-voice valid bits, and idles the sequencer.
module polyphonic_waveform_oscillator #(
    parameter int unsigned VOICES          = 16,
    parameter int unsigned SINE_TABLE_BITS = 10
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  pwo_pkg::t_item                 i_item,
    output logic                           o_result_strobe,
    output pwo_pkg::t_result               o_result,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [pwo_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [31:0]                    i_cfg_data
);
    import pwo_pkg::*;

    t_cfg    r_cfg;
    t_dp_cmd w_cmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.waveform       <= WAVE_SINE;
            r_cfg.octave_shift   <= 5'sd0;
            r_cfg.semitone_shift <= 5'sd0;
            r_cfg.cents_shift    <= 8'sd0;
            r_cfg.phase_scale    <= PHASE_SCALE_RESET;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_WAVEFORM:       r_cfg.waveform       <= t_wave'(i_cfg_data[1:0]);
                REG_OCTAVE_SHIFT:   r_cfg.octave_shift   <= signed'(i_cfg_data[4:0]);
                REG_SEMITONE_SHIFT: r_cfg.semitone_shift <= signed'(i_cfg_data[4:0]);
                REG_CENTS_SHIFT:    r_cfg.cents_shift    <= signed'(i_cfg_data[7:0]);
                REG_PHASE_SCALE:    r_cfg.phase_scale    <= i_cfg_data;
                default:            r_cfg                <= r_cfg;
            endcase
        end
    end

    pwo_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (w_cmd)
    );

    pwo_datapath #(
        .VOICES          (VOICES),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_cfg           (r_cfg),
        .i_item          (i_item),
        .o_result_strobe (o_result_strobe),
        .o_result        (o_result)
    );

endmodule
